FILE: rtl/core/msrr_pkg.sv
// Shared types, operation codes and constants for the motor speed ramp reverser.
`default_nettype none

package msrr_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SPEED = 2'd1;
    localparam logic [1:0] OP_DIR   = 2'd2;

    // Speed limit in percent and the ramp step after reset.
    localparam logic [7:0] SPEED_MAX       = 8'd100;
    localparam logic [6:0] RAMP_STEP_RESET = 7'd5;

    // Duty is speed*102/10. The divide by ten is folded into one constant
    // multiply: 102 * ceil(2^19 / 10) = 5347758, then a shift right by 19.
    localparam int         DUTY_SHIFT = 19;
    localparam logic [29:0] DUTY_MUL  = 30'd5347758;

    typedef struct packed {
        logic       forward;
        logic [7:0] speed;
        logic [1:0] operation;
    } item_t;

    typedef struct packed {
        logic [6:0] present_speed;
        logic [6:0] target_speed;
        logic       ramping_up;
        logic       direction_forward;
        logic       reversal_pending;
        logic [6:0] saved_target;
    } state_t;

    // Declared from the top bit down so that pwm_reverse sits in the lowest bits.
    typedef struct packed {
        logic       at_target;
        logic       reversing;
        logic       moving_forward;
        logic [6:0] speed_now;
        logic [9:0] pwm_forward;
        logic [9:0] pwm_reverse;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/msrr_update.sv
// Next-state and result logic for one tick, speed command or direction command.
`default_nettype none

module msrr_update (
    input  msrr_pkg::state_t  state_cur,
    input  msrr_pkg::item_t   item,
    input  logic [6:0]        ramp_step,
    output msrr_pkg::state_t  state_nxt,
    output msrr_pkg::result_t result
);
    import msrr_pkg::*;

    logic [7:0]  up_sum;
    logic [6:0]  down_diff;
    logic [6:0]  ramped;
    logic [29:0] duty_prod;
    logic [9:0]  duty;

    // Candidate speeds one step up and one step down.
    assign up_sum    = {1'b0, state_cur.present_speed} + {1'b0, ramp_step};
    assign down_diff = state_cur.present_speed - ramp_step;

    // Speed after a tick: one step toward the target, or the target itself.
    always_comb begin
        if (state_cur.ramping_up) begin
            if ({1'b0, state_cur.target_speed} >= up_sum) begin
                ramped = up_sum[6:0];
            end else begin
                ramped = state_cur.target_speed;
            end
        end else begin
            if ((state_cur.present_speed >= ramp_step) &&
                (state_cur.target_speed <= down_diff)) begin
                ramped = down_diff;
            end else begin
                ramped = state_cur.target_speed;
            end
        end
    end

    // State update by operation.
    always_comb begin
        state_nxt = state_cur;
        case (item.operation)
            OP_TICK: begin
                state_nxt.present_speed = ramped;
                // Once the ramp-down of a reversal lands, flip and head back
                // toward the saved target.
                if (state_cur.reversal_pending && (ramped == state_cur.target_speed)) begin
                    state_nxt.direction_forward = ~state_cur.direction_forward;
                    state_nxt.reversal_pending  = 1'b0;
                    if (state_cur.saved_target != ramped) begin
                        state_nxt.ramping_up   = (ramped < state_cur.saved_target);
                        state_nxt.target_speed = state_cur.saved_target;
                    end
                end
            end
            OP_SPEED: begin
                if (!state_cur.reversal_pending && (item.speed <= SPEED_MAX) &&
                    (item.speed != {1'b0, state_cur.present_speed})) begin
                    state_nxt.ramping_up   = ({1'b0, state_cur.present_speed} < item.speed);
                    state_nxt.target_speed = item.speed[6:0];
                end
            end
            OP_DIR: begin
                if (!state_cur.reversal_pending) begin
                    if (state_cur.present_speed == 7'd0) begin
                        // Standing still: the new direction applies at once.
                        state_nxt.direction_forward = item.forward;
                        if (state_cur.target_speed != 7'd0) begin
                            state_nxt.ramping_up = 1'b1;
                        end
                    end else begin
                        state_nxt.saved_target     = state_cur.target_speed;
                        state_nxt.target_speed     = 7'd0;
                        state_nxt.ramping_up       = 1'b0;
                        state_nxt.reversal_pending = 1'b1;
                    end
                end
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase
    end

    // Bridge duty of the active channel.
    assign duty_prod = 30'(state_nxt.present_speed) * DUTY_MUL;
    assign duty      = duty_prod[DUTY_SHIFT +: 10];

    // Result beat built from the updated state.
    always_comb begin
        result.pwm_reverse    = state_nxt.direction_forward ? 10'd0 : duty;
        result.pwm_forward    = state_nxt.direction_forward ? duty : 10'd0;
        result.speed_now      = state_nxt.present_speed;
        result.moving_forward = state_nxt.direction_forward;
        result.reversing      = state_nxt.reversal_pending;
        result.at_target      = (state_nxt.present_speed == state_nxt.target_speed);
    end

endmodule

`default_nettype wire

FILE: rtl/core/motor_speed_ramp_reverser_unit.sv
// Top level of the motor speed ramp reverser: beat registers, state and ramp step register.
// Each input beat (tick, speed command or direction command) yields exactly one result
// beat showing the motor state after the update. The block takes one beat per clock while
// m_tready does not stall the result register; a beat passes the input register, then the
// result register, and the rate is set by the combinational state update between them.
// An empty input register can take a new beat while the previous result waits on m_tready.
// ramp_step resets to 5; a write above 100 is dropped and the old step kept.
`default_nettype none

module motor_speed_ramp_reverser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write: ramp step in percent per tick.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] speed, [8] forward, [15:9] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [9:0] pwm_reverse, [19:10] pwm_forward,
                                        // [26:20] speed_now, [27] moving_forward,
                                        // [28] reversing, [29] at_target, [31:30] zero
);
    import msrr_pkg::*;

    logic     in_valid_reg;
    item_t    in_item_reg;
    logic     out_valid_reg;
    result_t  out_data_reg;
    state_t   state_reg;
    state_t   state_next;
    result_t  result_next;
    logic [6:0] step_reg;
    logic     advance;

    // Handshake: the input register moves on whenever the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_data_reg};

    // Ramp step register, writes above the limit are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= RAMP_STEP_RESET;
        end else if (cfg_valid && cfg_ready && ({1'b0, cfg_data} <= SPEED_MAX)) begin
            step_reg <= cfg_data;
        end
    end

    // Input beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation <= s_tuser;
            in_item_reg.speed     <= s_tdata[7:0];
            in_item_reg.forward   <= s_tdata[8];
        end
    end

    // Update logic between the input and result registers.
    msrr_update u_update (
        .state_cur (state_reg),
        .item      (in_item_reg),
        .ramp_step (step_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // Motor state, committed as the beat moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.present_speed     <= 7'd0;
            state_reg.target_speed      <= 7'd0;
            state_reg.ramping_up        <= 1'b1;
            state_reg.direction_forward <= 1'b1;
            state_reg.reversal_pending  <= 1'b0;
            state_reg.saved_target      <= 7'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/msrr_checker.sv
// Port-level checks for the motor speed ramp reverser and the bind that attaches them.
`default_nettype none

module msrr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result beat keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only one bridge channel is ever driven.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:0] == 10'd0) || (m_tdata[19:10] == 10'd0))
        else $error("both bridge channels driven");

    // The reported speed never leaves the percent range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[26:20] <= 7'd100)
        else $error("speed above 100 percent");

    // A stopped motor has no duty on either channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[26:20] == 7'd0) |->
            (m_tdata[9:0] == 10'd0) && (m_tdata[19:10] == 10'd0))
        else $error("duty driven at zero speed");

    // While moving forward, the reverse channel is not driven.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tdata[9:0] == 10'd0)
        else $error("reverse channel driven while moving forward");

endmodule

bind motor_speed_ramp_reverser_unit msrr_checker u_msrr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
